/* hdl/desm_pkg.sv */
// Shared types and constants for the dual EWMA load smoother.
package desm_pkg;

    localparam int METER_W    = 4;
    localparam int SAMPLE_W   = 32;
    localparam int FALLBACK_W = 23;
    localparam int AVG_W      = 31;
    localparam int DECAY_W    = 8;
    localparam int MASK_W     = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_MINUTE_DECAY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOUR_DECAY     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESCALED_MASK = 2'd2;

    localparam logic [DECAY_W-1:0] MINUTE_DECAY_RST   = 8'd0;
    localparam logic [DECAY_W-1:0] HOUR_DECAY_RST     = 8'd230;
    localparam logic [MASK_W-1:0]  PRESCALED_MASK_RST = 10'd896;

    typedef logic [AVG_W-1:0] avg_t;

    // result of one average update
    typedef struct packed {
        avg_t avg;
        logic wrapped;
    } blend_res_t;

endpackage

/* hdl/desm_if.sv */
// Channel interfaces of the dual EWMA load smoother: sample, result and configuration.
interface desm_in_if;
    logic                                     valid;
    logic                                     ready;
    logic [desm_pkg::METER_W-1:0]             meter_index;
    logic signed [desm_pkg::SAMPLE_W-1:0]     raw_sample;
    logic [desm_pkg::FALLBACK_W-1:0]          fallback_max;

    modport source (output valid, meter_index, raw_sample, fallback_max, input ready);
    modport sink   (input valid, meter_index, raw_sample, fallback_max, output ready);
endinterface

interface desm_out_if;
    logic                         valid;
    logic                         ready;
    logic [desm_pkg::METER_W-1:0] meter_echo;
    logic [desm_pkg::AVG_W-1:0]   minute_average;
    logic [desm_pkg::AVG_W-1:0]   hour_average;
    logic                         minute_wrapped;
    logic                         hour_wrapped;

    modport source (output valid, meter_echo, minute_average, hour_average,
                    minute_wrapped, hour_wrapped, input ready);
    modport sink   (input valid, meter_echo, minute_average, hour_average,
                    minute_wrapped, hour_wrapped, output ready);
endinterface

interface desm_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [desm_pkg::CFG_IDX_W-1:0]  index;
    logic [desm_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/desm_term.sv */
// Sample conditioning: clamp, scale to fixed point, optional divide back for prescaled meters.
module desm_term #(
    parameter int FRACTION_BITS = 8
) (
    input  logic [desm_pkg::METER_W-1:0]         meter_index,
    input  logic signed [desm_pkg::SAMPLE_W-1:0] raw_sample,
    input  logic [desm_pkg::MASK_W-1:0]          prescaled_mask,
    output logic [31:0]                          term
);

    logic [31:0] clamped;
    logic [31:0] shifted;
    logic [31:0] neg_mag;
    logic [31:0] divided;
    logic        prescaled;

    // drop negative samples to zero
    assign clamped = raw_sample[31] ? 32'd0 : 32'(raw_sample);
    assign shifted = clamped << FRACTION_BITS;

    // signed divide by scale, rounding toward zero, on the wrapped product
    assign neg_mag = (32'd0 - shifted) >> FRACTION_BITS;
    assign divided = shifted[31] ? (32'd0 - neg_mag) : (shifted >> FRACTION_BITS);

    // meters past the mask register count as not prescaled
    assign prescaled = (32'(meter_index) < desm_pkg::MASK_W) &&
                       prescaled_mask[meter_index];

    assign term = prescaled ? divided : shifted;

endmodule

/* hdl/desm_blend.sv */
// One fixed-point exponential average update with wraparound fallback.
module desm_blend #(
    parameter int FRACTION_BITS = 8
) (
    input  logic [desm_pkg::DECAY_W-1:0]    decay,
    input  desm_pkg::avg_t                  prev,
    input  logic [31:0]                     term,
    input  logic [desm_pkg::FALLBACK_W-1:0] fallback,
    output desm_pkg::blend_res_t            res
);

    localparam logic [31:0] FSCALE = 32'd1 << FRACTION_BITS;

    logic [31:0] kept;
    logic [31:0] added;
    logic [31:0] sum;
    logic [31:0] fb_scaled;
    logic [31:0] shifted;

    // all products and sums wrap at 32 bits
    assign kept      = 32'(decay) * 32'(prev);
    assign added     = term * (FSCALE - 32'(decay));
    assign sum       = kept + added;
    assign fb_scaled = 32'(fallback) << FRACTION_BITS;
    assign shifted   = sum >> FRACTION_BITS;

    always_comb
    begin
        res.wrapped = sum[31];
        res.avg     = sum[31] ? fb_scaled[desm_pkg::AVG_W-1:0]
                              : shifted[desm_pkg::AVG_W-1:0];
    end

endmodule

/* hdl/dual_ewma_load_smoother_core.sv */
// Top level of the dual EWMA load smoother: channels, pipeline and per-meter state.
//
// Usage: each beat on in_ch carries one raw sample for one meter together
// with that meter's current full scale. The block clamps the sample,
// brings it to fixed point and updates a fast (minute) and a slow (hour)
// average for that meter. Every input beat yields exactly one beat on
// out_ch with the meter index, both new averages and two wrap flags.
// Meters at or above NUM_METERS leave state alone and report zeros.
// cfg_ch writes minute_decay, hour_decay and prescaled_mask by index;
// it is always ready, and writes belong in idle periods only.
// Between an input beat and its result beat lie the input register, then
// the result register. Throughput: one beat per cycle while out_ch takes
// results, as the two blend units finish the read-modify-write of the
// averages between the input and result registers.
// Reset: averages clear to zero, decays and mask take reset values, and
// both pipeline stages empty. When the receiver stalls, the result holds
// in its register, the input stage fills, and in_ch.ready then drops.
module dual_ewma_load_smoother_core #(
    parameter int NUM_METERS    = 10,
    parameter int FRACTION_BITS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    desm_in_if.sink    in_ch,
    desm_out_if.source out_ch,
    desm_cfg_if.sink   cfg_ch
);

    localparam int IDX_W = (NUM_METERS > 1) ? $clog2(NUM_METERS) : 1;

    // configuration registers
    logic [desm_pkg::DECAY_W-1:0] minute_decay_reg;
    logic [desm_pkg::DECAY_W-1:0] hour_decay_reg;
    logic [desm_pkg::MASK_W-1:0]  prescaled_mask_reg;

    // per-meter averages
    desm_pkg::avg_t minute_store_reg [NUM_METERS];
    desm_pkg::avg_t hour_store_reg   [NUM_METERS];

    // input stage
    logic                            s1_valid_reg;
    logic [desm_pkg::METER_W-1:0]    s1_meter_reg;
    logic [31:0]                     s1_term_reg;
    logic [desm_pkg::FALLBACK_W-1:0] s1_fallback_reg;

    // result stage
    logic                         out_valid_reg;
    logic [desm_pkg::METER_W-1:0] out_meter_reg;
    desm_pkg::avg_t               out_minute_reg;
    desm_pkg::avg_t               out_hour_reg;
    logic                         out_minute_wrap_reg;
    logic                         out_hour_wrap_reg;

    logic                 in_fire;
    logic                 s1_advance;
    logic                 s1_hit;
    logic [IDX_W-1:0]     s1_idx;
    logic [31:0]          in_term;
    desm_pkg::blend_res_t minute_res;
    desm_pkg::blend_res_t hour_res;

    // configuration write: always ready, unknown indexes ignored
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            minute_decay_reg   <= desm_pkg::MINUTE_DECAY_RST;
            hour_decay_reg     <= desm_pkg::HOUR_DECAY_RST;
            prescaled_mask_reg <= desm_pkg::PRESCALED_MASK_RST;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.index)
                desm_pkg::CFG_MINUTE_DECAY:
                    minute_decay_reg <= cfg_ch.data[desm_pkg::DECAY_W-1:0];
                desm_pkg::CFG_HOUR_DECAY:
                    hour_decay_reg <= cfg_ch.data[desm_pkg::DECAY_W-1:0];
                desm_pkg::CFG_PRESCALED_MASK:
                    prescaled_mask_reg <= cfg_ch.data;
                default:
                    ;
            endcase
        end
    end

    // flow control: the result register frees when empty or taken
    assign s1_advance  = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || s1_advance;
    assign in_fire     = in_ch.valid && in_ch.ready;

    // condition the sample on its way into the input register
    desm_term #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_term (
        .meter_index    (in_ch.meter_index),
        .raw_sample     (in_ch.raw_sample),
        .prescaled_mask (prescaled_mask_reg),
        .term           (in_term)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_meter_reg    <= in_ch.meter_index;
            s1_term_reg     <= in_term;
            s1_fallback_reg <= in_ch.fallback_max;
        end
    end

    // pick the meter's state; out-of-range meters never write it
    assign s1_hit = 32'(s1_meter_reg) < NUM_METERS;
    assign s1_idx = IDX_W'(s1_meter_reg);

    desm_blend #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_minute (
        .decay    (minute_decay_reg),
        .prev     (s1_hit ? minute_store_reg[s1_idx] : '0),
        .term     (s1_term_reg),
        .fallback (s1_fallback_reg),
        .res      (minute_res)
    );

    desm_blend #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_hour (
        .decay    (hour_decay_reg),
        .prev     (s1_hit ? hour_store_reg[s1_idx] : '0),
        .term     (s1_term_reg),
        .fallback (s1_fallback_reg),
        .res      (hour_res)
    );

    // write back the averages at the same edge the result is captured,
    // so the next beat for the same meter already sees them
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_METERS; i++)
            begin
                minute_store_reg[i] <= '0;
                hour_store_reg[i]   <= '0;
            end
        end
        else if (s1_advance && s1_hit)
        begin
            minute_store_reg[s1_idx] <= minute_res.avg;
            hour_store_reg[s1_idx]   <= hour_res.avg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ch.ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_meter_reg       <= s1_meter_reg;
            out_minute_reg      <= s1_hit ? minute_res.avg : '0;
            out_hour_reg        <= s1_hit ? hour_res.avg : '0;
            out_minute_wrap_reg <= s1_hit && minute_res.wrapped;
            out_hour_wrap_reg   <= s1_hit && hour_res.wrapped;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.meter_echo     = out_meter_reg;
    assign out_ch.minute_average = out_minute_reg;
    assign out_ch.hour_average   = out_hour_reg;
    assign out_ch.minute_wrapped = out_minute_wrap_reg;
    assign out_ch.hour_wrapped   = out_hour_wrap_reg;

    // a stalled input stage keeps its beat
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_advance |=> s1_valid_reg)
        else $error("input stage dropped a beat while stalled");

    // an out-of-range meter reports all zeros
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (32'(out_meter_reg) >= NUM_METERS) |->
        (out_minute_reg == '0) && (out_hour_reg == '0) &&
        !out_minute_wrap_reg && !out_hour_wrap_reg)
        else $error("out-of-range meter reported nonzero result");

    // the stored averages match the reported ones after an update
    a_store_match: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && s1_hit |=>
        (minute_store_reg[$past(s1_idx)] == out_minute_reg) &&
        (hour_store_reg[$past(s1_idx)] == out_hour_reg))
        else $error("stored average differs from reported result");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for dual_ewma_load_smoother_core: directed table, then random phases.
module testbench;

    localparam int NUM_METERS     = 10;
    localparam int FRACTION_BITS  = 8;
    localparam logic [31:0] FSCALE = 32'd1 << FRACTION_BITS;

    localparam int NUM_PHASES     = 6;
    localparam int PHASE_ITEMS    = 255;
    localparam int HOLDOFF_CYCLES = 60;
    localparam int DRAIN_CYCLES   = 8;
    localparam int LIMIT_CYCLES   = 400000;

    // one result beat as the block reports it
    typedef struct packed {
        logic [desm_pkg::METER_W-1:0] meter;
        desm_pkg::avg_t               minute;
        desm_pkg::avg_t               hour;
        logic                         minute_wrapped;
        logic                         hour_wrapped;
    } smoothed_t;

    // one row of the directed table; typed rows carry their result spelled out
    typedef struct packed {
        logic [desm_pkg::METER_W-1:0]    meter;
        logic [desm_pkg::SAMPLE_W-1:0]   sample;
        logic [desm_pkg::FALLBACK_W-1:0] fallback;
        logic                            typed;
        smoothed_t                       result;
    } directed_row_t;

    typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

    localparam int NUM_DIRECTED = 20;

    // Directed rows run under reset settings: minute decay 0, hour decay 230,
    // meters 7..9 prescaled. Typed rows can be worked out by hand.
    localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        // all zero on a fresh meter
        '{4'd0,  32'h0000_0000, 23'h000000, 1'b1, '{4'd0,  31'd0, 31'd0, 1'b0, 1'b0}},
        // meter out of range, largest sample: state untouched, zeros back
        '{4'd15, 32'h7FFF_FFFF, 23'h7FFFFF, 1'b1, '{4'd15, 31'd0, 31'd0, 1'b0, 1'b0}},
        '{4'd10, 32'h0000_3039, 23'h000000, 1'b1, '{4'd10, 31'd0, 31'd0, 1'b0, 1'b0}},
        // negative samples clamp to zero
        '{4'd1,  32'h8000_0000, 23'h7FFFFF, 1'b1, '{4'd1,  31'd0, 31'd0, 1'b0, 1'b0}},
        '{4'd2,  32'hFFFF_FFFF, 23'h000001, 1'b1, '{4'd2,  31'd0, 31'd0, 1'b0, 1'b0}},
        // unit sample: minute takes it whole, hour keeps 26/256 of it
        '{4'd3,  32'h0000_0001, 23'h000000, 1'b1, '{4'd3,  31'd256, 31'd26, 1'b0, 1'b0}},
        // largest sample wraps both sums: fallback at full scale
        '{4'd4,  32'h7FFF_FFFF, 23'h7FFFFF, 1'b1,
            '{4'd4, 31'h7FFF_FF00, 31'h7FFF_FF00, 1'b1, 1'b1}},
        // prescaled meter, largest sample: term becomes -1, both wrap, fallback zero
        '{4'd9,  32'h7FFF_FFFF, 23'h000000, 1'b1, '{4'd9,  31'd0, 31'd0, 1'b1, 1'b1}},
        '{4'd5,  32'h0000_03E8, 23'h000064, 1'b0, '0},
        '{4'd5,  32'h0000_03E8, 23'h000064, 1'b0, '0},
        '{4'd7,  32'h0001_2345, 23'h000005, 1'b0, '0},
        // prescaled meter whose shifted term turns negative
        '{4'd8,  32'h0080_0000, 23'h400000, 1'b0, '0},
        '{4'd6,  32'h00FF_FFFF, 23'h7FFFFF, 1'b0, '0},
        '{4'd0,  32'h007F_FFFF, 23'h123456, 1'b0, '0},
        '{4'd9,  32'h0000_7FFF, 23'h7FFFFF, 1'b0, '0},
        '{4'd11, 32'h0000_0000, 23'h000000, 1'b1, '{4'd11, 31'd0, 31'd0, 1'b0, 1'b0}},
        '{4'd3,  32'h0000_1000, 23'h000003, 1'b0, '0},
        '{4'd4,  32'h0000_0000, 23'h000000, 1'b0, '0},
        '{4'd12, 32'h5555_5555, 23'h2AAAAA, 1'b1, '{4'd12, 31'd0, 31'd0, 1'b0, 1'b0}},
        '{4'd14, 32'hAAAA_AAAA, 23'h555555, 1'b1, '{4'd14, 31'd0, 31'd0, 1'b0, 1'b0}}
    };

    logic clk = 1'b0;
    logic rst_n;

    desm_in_if  in_ch ();
    desm_out_if out_ch ();
    desm_cfg_if cfg_ch ();

    dual_ewma_load_smoother_core #(
        .NUM_METERS    (NUM_METERS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Shadow of the block: settings and both per-meter average stores.
    logic [desm_pkg::DECAY_W-1:0] minute_decay_q   = desm_pkg::MINUTE_DECAY_RST;
    logic [desm_pkg::DECAY_W-1:0] hour_decay_q     = desm_pkg::HOUR_DECAY_RST;
    logic [desm_pkg::MASK_W-1:0]  prescaled_mask_q = desm_pkg::PRESCALED_MASK_RST;
    desm_pkg::avg_t               minute_hist [NUM_METERS] = '{default: '0};
    desm_pkg::avg_t               hour_hist   [NUM_METERS] = '{default: '0};

    smoothed_t     pending_averages [$];
    directed_row_t typed_rows [$];
    int unsigned   error_count = 0;
    int unsigned   cycle_count = 0;

    bit          holdoff_req  = 1'b0;
    int unsigned holdoff_left = 0;

    // One average update: weighted sum at 32 bits; a set sign bit means the
    // sum wrapped, so fall back to the meter's full scale in fixed point.
    function automatic desm_pkg::blend_res_t apply_decay(input logic [31:0] decay,
                                                         input logic [31:0] prev,
                                                         input logic [31:0] term,
                                                         input logic [31:0] fallback);
        logic [31:0]          sum;
        logic [31:0]          scaled;
        desm_pkg::blend_res_t res;
        sum = decay * prev + term * (FSCALE - decay);
        if (sum[31])
        begin
            scaled      = fallback * FSCALE;
            res.wrapped = 1'b1;
            res.avg     = scaled[desm_pkg::AVG_W-1:0];
        end
        else
        begin
            scaled      = sum >> FRACTION_BITS;
            res.wrapped = 1'b0;
            res.avg     = scaled[desm_pkg::AVG_W-1:0];
        end
        return res;
    endfunction

    // Work out the result beat for one sample and advance the shadow stores.
    function automatic smoothed_t smooth_sample(
        input logic [desm_pkg::METER_W-1:0]    meter,
        input logic [desm_pkg::SAMPLE_W-1:0]   sample,
        input logic [desm_pkg::FALLBACK_W-1:0] fallback);
        smoothed_t            res;
        logic [31:0]          term;
        logic [31:0]          mag;
        desm_pkg::blend_res_t mn;
        desm_pkg::blend_res_t hr;
        res       = '0;
        res.meter = meter;
        if (meter >= NUM_METERS)
            return res;

        term = sample[31] ? 32'd0 : (sample << FRACTION_BITS);
        // prescaled meters divide the wrapped term back down, rounding toward zero
        if (meter < desm_pkg::MASK_W && prescaled_mask_q[meter])
        begin
            if (term[31])
            begin
                mag  = (32'd0 - term) >> FRACTION_BITS;
                term = 32'd0 - mag;
            end
            else
                term = term >> FRACTION_BITS;
        end

        mn = apply_decay({24'd0, minute_decay_q}, {1'b0, minute_hist[meter]}, term,
                         {9'd0, fallback});
        hr = apply_decay({24'd0, hour_decay_q}, {1'b0, hour_hist[meter]}, term,
                         {9'd0, fallback});
        minute_hist[meter] = mn.avg;
        hour_hist[meter]   = hr.avg;
        res.minute         = mn.avg;
        res.hour           = hr.avg;
        res.minute_wrapped = mn.wrapped;
        res.hour_wrapped   = hr.wrapped;
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        error_count++;
    endtask

    // Monitor: everything here samples at the rising edge, before the block's
    // registers move, so the values seen are the ones that made the beat.
    smoothed_t     predicted;
    smoothed_t     want;
    directed_row_t typed_row;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // track register writes so the predictor uses the same settings
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    desm_pkg::CFG_MINUTE_DECAY:
                        minute_decay_q = cfg_ch.data[desm_pkg::DECAY_W-1:0];
                    desm_pkg::CFG_HOUR_DECAY:
                        hour_decay_q = cfg_ch.data[desm_pkg::DECAY_W-1:0];
                    desm_pkg::CFG_PRESCALED_MASK:
                        prescaled_mask_q = cfg_ch.data[desm_pkg::MASK_W-1:0];
                    default: ;
                endcase
            end

            // every accepted sample beat queues exactly one expected result;
            // a typed directed row overrides the predicted value but the
            // predictor still runs so its stores stay in step
            if (in_ch.valid && in_ch.ready)
            begin
                predicted = smooth_sample(in_ch.meter_index, in_ch.raw_sample,
                                          in_ch.fallback_max);
                if (typed_rows.size() != 0)
                begin
                    typed_row = typed_rows.pop_front();
                    if (typed_row.typed)
                        predicted = typed_row.result;
                end
                pending_averages.push_back(predicted);
            end

            // compare each result beat with the oldest expectation
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_averages.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, actual meter %0d",
                             $time, out_ch.meter_echo);
                    error_count++;
                end
                else
                begin
                    want = pending_averages.pop_front();
                    if (out_ch.meter_echo !== want.meter)
                        report_mismatch("meter_echo", 32'(want.meter), 32'(out_ch.meter_echo));
                    if (out_ch.minute_average !== want.minute)
                        report_mismatch("minute_average", 32'(want.minute),
                                        32'(out_ch.minute_average));
                    if (out_ch.hour_average !== want.hour)
                        report_mismatch("hour_average", 32'(want.hour),
                                        32'(out_ch.hour_average));
                    if (out_ch.minute_wrapped !== want.minute_wrapped)
                        report_mismatch("minute_wrapped", 32'(want.minute_wrapped),
                                        32'(out_ch.minute_wrapped));
                    if (out_ch.hour_wrapped !== want.hour_wrapped)
                        report_mismatch("hour_wrapped", 32'(want.hour_wrapped),
                                        32'(out_ch.hour_wrapped));
                end
            end
        end
    end

    // Receiver: change ready at the falling edge only. Switch between
    // always-ready stretches, random stalls and a fixed stall pattern; on
    // request, hold off for a long stretch so the block backs up into in_ch.
    rx_mode_t    rx_mode      = RX_ALWAYS;
    int unsigned rx_mode_left = 0;
    int unsigned rx_tick      = 0;

    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rx_tick++;
            if (holdoff_left == 0 && holdoff_req)
            begin
                holdoff_left = HOLDOFF_CYCLES;
                holdoff_req  = 1'b0;
            end
            if (holdoff_left != 0)
            begin
                holdoff_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                if (rx_mode_left == 0)
                begin
                    rx_mode      = rx_mode_t'($urandom_range(0, 2));
                    rx_mode_left = $urandom_range(20, 200);
                end
                rx_mode_left--;
                case (rx_mode)
                    RX_ALWAYS:  out_ch.ready <= 1'b1;
                    RX_RANDOM:  out_ch.ready <= ($urandom_range(0, 99) >= 35);
                    RX_PATTERN: out_ch.ready <= ((rx_tick % 7) < 4);
                    default:    out_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    // Watchdog: end the run as failed once the cycle counter reaches its limit.
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles, %0d results outstanding",
                 $time, cycle_count, pending_averages.size());
        $display("Some tests failed");
        $finish;
    end

    // Offer one sample beat, hold it until accepted, then idle for the requested gap.
    // Enter and leave at a falling edge; valid stays high if gap is zero.
    task automatic send_sample(input logic [desm_pkg::METER_W-1:0] meter,
                               input logic [desm_pkg::SAMPLE_W-1:0] sample,
                               input logic [desm_pkg::FALLBACK_W-1:0] fallback,
                               input int unsigned gap);
        in_ch.valid        <= 1'b1;
        in_ch.meter_index  <= meter;
        in_ch.raw_sample   <= sample;
        in_ch.fallback_max <= fallback;
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Stop offering, wait until every expected result has arrived, then let the pipeline settle.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_averages.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Write one register beat; only called while the block is idle.
    task automatic write_register(input logic [desm_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [desm_pkg::CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Random sample: a third small values so averages settle without wrapping,
    // plus mid range, full range, negatives and the extremes.
    function automatic logic [desm_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 11))
            0, 1, 2, 3: return 32'($urandom_range(0, 32'h7FFF));
            4, 5:       return 32'($urandom_range(0, 32'h7F_FFFF));
            6, 7:       return 32'($urandom);
            8:          return 32'h8000_0000 | 32'($urandom);
            9:          return 32'h7FFF_FFFF;
            10:         return 32'h8000_0000;
            default:    return ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [desm_pkg::FALLBACK_W-1:0] pick_fallback();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return desm_pkg::FALLBACK_W'($urandom);
        endcase
    endfunction

    // Main sequence: reset, directed table, then random phases under
    // changing settings, with bursts and gaps on the sending side.
    logic [desm_pkg::DECAY_W-1:0] minute_setting;
    logic [desm_pkg::DECAY_W-1:0] hour_setting;
    logic [desm_pkg::MASK_W-1:0]  mask_setting;
    int unsigned                  burst_left;
    int unsigned                  burst_gap;
    int unsigned                  gap;
    logic [desm_pkg::METER_W-1:0] meter;

    initial
    begin
        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.meter_index  = '0;
        in_ch.raw_sample   = '0;
        in_ch.fallback_max = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = desm_pkg::CFG_MINUTE_DECAY;
        cfg_ch.data        = '0;
        burst_left         = 0;
        burst_gap          = 0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table under reset settings
        for (int r = 0; r < NUM_DIRECTED; r++)
        begin
            typed_rows.push_back(DIRECTED_ROWS[r]);
            send_sample(DIRECTED_ROWS[r].meter, DIRECTED_ROWS[r].sample,
                        DIRECTED_ROWS[r].fallback, $urandom_range(0, 2));
        end
        drain_results();

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    minute_setting = desm_pkg::MINUTE_DECAY_RST;
                    hour_setting   = desm_pkg::HOUR_DECAY_RST;
                    mask_setting   = desm_pkg::PRESCALED_MASK_RST;
                end
                1:
                begin
                    minute_setting = 8'd255;
                    hour_setting   = 8'd255;
                    mask_setting   = '1;
                end
                2:
                begin
                    minute_setting = 8'd0;
                    hour_setting   = 8'd0;
                    mask_setting   = '0;
                end
                3:
                begin
                    minute_setting = 8'd1;
                    hour_setting   = 8'd254;
                    mask_setting   = 10'h155;
                end
                default:
                begin
                    minute_setting = desm_pkg::DECAY_W'($urandom);
                    hour_setting   = desm_pkg::DECAY_W'($urandom);
                    mask_setting   = desm_pkg::MASK_W'($urandom);
                end
            endcase
            write_register(desm_pkg::CFG_MINUTE_DECAY,
                           desm_pkg::CFG_DATA_W'(minute_setting));
            write_register(desm_pkg::CFG_HOUR_DECAY,
                           desm_pkg::CFG_DATA_W'(hour_setting));
            write_register(desm_pkg::CFG_PRESCALED_MASK, mask_setting);

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // a quarter in: stall the receiver while samples keep coming
                if (i == PHASE_ITEMS / 4)
                    holdoff_req = 1'b1;
                // halfway: pause the sender until the block is empty
                if (i == PHASE_ITEMS / 2)
                    drain_results();

                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    burst_gap  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                burst_left--;
                gap = (burst_left == 0) ? burst_gap : 0;

                if ($urandom_range(0, 99) < 88)
                    meter = desm_pkg::METER_W'($urandom_range(0, NUM_METERS - 1));
                else
                    meter = desm_pkg::METER_W'($urandom_range(NUM_METERS, 15));
                send_sample(meter, pick_sample(), pick_fallback(), gap);
            end
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_averages.size() != 0)
        begin
            $display("%0t: %0d results missing, expected meter %0d next, actual none",
                     $time, pending_averages.size(), pending_averages[0].meter);
            error_count++;
        end
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
